FILE: design/tci_pkg.sv
`timescale 1ns / 1ps

package tci_pkg;

   localparam int CH_W = 2;

   localparam logic [1:0] MODE_LATCH = 2'd0;
   localparam logic [1:0] MODE_LOW   = 2'd1;
   localparam logic [1:0] MODE_HIGH  = 2'd2;
   localparam logic [1:0] MODE_BOTH  = 2'd3;

   // per channel command decoded from one item
   typedef struct packed {
      logic       tick;
      logic       latch;
      logic       ctrl;
      logic       wr;
      logic       rd;
      logic [7:0] data;
   } tci_op_type;

endpackage

FILE: design/tci_chan.sv
`timescale 1ns / 1ps

module tci_chan (
   input  logic               clock,
   input  logic               reset,
   input  tci_pkg::tci_op_type op,
   input  logic [15:0]        divide,
   output logic [7:0]         rd_byte,
   output logic               wrap
);

   logic [15:0] reload_ff,   reload_in;
   logic [7:0]  control_ff,  control_in;
   logic        wphase_ff,   wphase_in;
   logic        rphase_ff,   rphase_in;
   logic        held_ff,     held_in;
   logic [15:0] latched_ff,  latched_in;
   logic        running_ff,  running_in;
   logic [15:0] count_ff,    count_in;
   logic [15:0] prescale_ff, prescale_in;

   logic [1:0]  mode;
   logic [15:0] visible;
   logic [15:0] rd_value;
   logic [16:0] pre_next;
   logic        done;

   assign mode     = control_ff[5:4];
   assign visible  = running_ff ? count_ff : reload_ff;
   assign rd_value = held_ff ? latched_ff : visible;
   assign pre_next = {1'b0, prescale_ff} + 17'd1;

   always_comb begin
      reload_in   = reload_ff;
      control_in  = control_ff;
      wphase_in   = wphase_ff;
      rphase_in   = rphase_ff;
      held_in     = held_ff;
      latched_in  = latched_ff;
      running_in  = running_ff;
      count_in    = count_ff;
      prescale_in = prescale_ff;
      rd_byte     = 8'd0;
      wrap        = 1'b0;
      done        = 1'b0;

      if (op.tick) begin
         if (running_ff) begin
            if (pre_next < {1'b0, divide}) begin
               prescale_in = pre_next[15:0];
            end else begin
               prescale_in = 16'd0;
               if (count_ff == 16'd0) begin
                  count_in = reload_ff - 16'd1;
                  wrap     = 1'b1;
               end else begin
                  count_in = count_ff - 16'd1;
               end
            end
         end
      end else if (op.latch) begin
         latched_in = visible;
         held_in    = 1'b1;
         rphase_in  = 1'b0;
      end else if (op.ctrl) begin
         control_in = op.data;
         wphase_in  = 1'b0;
         rphase_in  = 1'b0;
         running_in = 1'b0;
      end else if (op.wr) begin
         // stored mode zero only occurs before any control write, acts as low then high
         priority if (mode == tci_pkg::MODE_LOW) begin
            reload_in = {reload_ff[15:8], op.data};
            done      = 1'b1;
         end else if (mode == tci_pkg::MODE_HIGH) begin
            reload_in = {op.data, reload_ff[7:0]};
            done      = 1'b1;
         end else if (!wphase_ff) begin
            reload_in = {reload_ff[15:8], op.data};
            wphase_in = 1'b1;
         end else begin
            reload_in = {op.data, reload_ff[7:0]};
            wphase_in = 1'b0;
            done      = 1'b1;
         end
         if (done) begin
            running_in  = 1'b1;
            count_in    = reload_in - 16'd1;
            prescale_in = 16'd0;
         end
      end else if (op.rd) begin
         priority if (mode == tci_pkg::MODE_LOW) begin
            held_in = 1'b0;
            rd_byte = rd_value[7:0];
         end else if (mode == tci_pkg::MODE_HIGH) begin
            held_in = 1'b0;
            rd_byte = rd_value[15:8];
         end else if (!rphase_ff) begin
            rphase_in = 1'b1;
            rd_byte   = rd_value[7:0];
         end else begin
            rphase_in = 1'b0;
            held_in   = 1'b0;
            rd_byte   = rd_value[15:8];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff   <= 16'd0;
         control_ff  <= 8'd0;
         wphase_ff   <= 1'b0;
         rphase_ff   <= 1'b0;
         held_ff     <= 1'b0;
         latched_ff  <= 16'd0;
         running_ff  <= 1'b0;
         count_ff    <= 16'd0;
         prescale_ff <= 16'd0;
      end else begin
         reload_ff   <= reload_in;
         control_ff  <= control_in;
         wphase_ff   <= wphase_in;
         rphase_ff   <= rphase_in;
         held_ff     <= held_in;
         latched_ff  <= latched_in;
         running_ff  <= running_in;
         count_ff    <= count_in;
         prescale_ff <= prescale_in;
      end
   end

endmodule

FILE: design/three_channel_interval_timer.sv
`timescale 1ns / 1ps

// Three channel interval timer in the style of the classic 8253, driven by a
// stream of operations: clock tick, control write, counter write and counter
// read. Every item gives exactly one result item carrying the read byte (zero
// for anything but a read) and the channel 0 wrap flag. An item passes through
// an input register and then a result register before its result is
// presented, and one item is taken every clock while the result side keeps
// up. The prescaler divide value on the csr port is shared by all channels,
// a value of zero acts as one, and the user must write it only while the
// block has no items in flight; the block itself does not enforce this.
module three_channel_interval_timer #(
   parameter int CHANNELS = 3
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte[7:0]
   input  logic [3:0]  req_tuser,   // opcode[1:0], channel[3:2]

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // rd_data[7:0], timer0_expired[8], zero[15:9]
);

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_CTRL  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   logic [15:0] divide_ff;

   logic        in_valid_ff;
   logic [1:0]  opcode_ff;
   logic [tci_pkg::CH_W-1:0] chan_ff;
   logic [7:0]  byte_ff;

   logic        rsp_valid_ff;
   logic [7:0]  rd_data_ff, rd_data_in;
   logic        expired_ff;

   logic        advance;
   logic        fire;
   logic [15:0] divide_eff;
   logic        expired_w;
   logic [7:0]  rd_byte_w [CHANNELS];
   tci_pkg::tci_op_type op_w [CHANNELS];

   assign csr_ready  = 1'b1;
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign divide_eff = (divide_ff == 16'd0) ? 16'd1 : divide_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         divide_ff <= 16'd1;
      end else if (csr_valid && csr_ready) begin
         divide_ff <= csr_data;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         opcode_ff <= req_tuser[1:0];
         chan_ff   <= req_tuser[3:2];
         byte_ff   <= req_tdata;
      end
   end

   for (genvar k = 0; k < CHANNELS; k++) begin : g_chan
      logic sel_hit;
      logic chan_hit;

      assign sel_hit  = byte_ff[7:6] == tci_pkg::CH_W'(k);
      assign chan_hit = chan_ff == tci_pkg::CH_W'(k);

      always_comb begin
         op_w[k].tick  = fire && (opcode_ff == OP_TICK);
         op_w[k].latch = fire && (opcode_ff == OP_CTRL) && sel_hit
                         && (byte_ff[5:4] == tci_pkg::MODE_LATCH);
         op_w[k].ctrl  = fire && (opcode_ff == OP_CTRL) && sel_hit
                         && (byte_ff[5:4] != tci_pkg::MODE_LATCH);
         op_w[k].wr    = fire && (opcode_ff == OP_WRITE) && chan_hit;
         op_w[k].rd    = fire && (opcode_ff == OP_READ) && chan_hit;
         op_w[k].data  = byte_ff;
      end

      if (k == 0) begin : g_first
         tci_chan u_chan (
            .clock   (clock),
            .reset   (reset),
            .op      (op_w[k]),
            .divide  (divide_eff),
            .rd_byte (rd_byte_w[k]),
            .wrap    (expired_w)
         );
      end else begin : g_rest
         tci_chan u_chan (
            .clock   (clock),
            .reset   (reset),
            .op      (op_w[k]),
            .divide  (divide_eff),
            .rd_byte (rd_byte_w[k]),
            .wrap    ()
         );
      end
   end

   // only the addressed channel drives a nonzero byte
   always_comb begin
      rd_data_in = 8'd0;
      for (int i = 0; i < CHANNELS; i++) begin
         rd_data_in = rd_data_in | rd_byte_w[i];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rd_data_ff <= rd_data_in;
         expired_ff <= expired_w;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, expired_ff, rd_data_ff};

endmodule
